@@ hw/rtl/stpg_pkg.sv @@
// ----------------------------------------------------------------------------
// stpg_pkg
// Types and constants shared by the speed-to-pulse generator.
// ----------------------------------------------------------------------------
package stpg_pkg;

  localparam int unsigned SpeedWidth = 16;
  localparam int unsigned PpmWidth   = 16;
  localparam int unsigned ProdWidth  = SpeedWidth + PpmWidth;
  localparam int unsigned NumWidth   = 28;
  localparam int unsigned StepCntW   = 5;
  localparam int unsigned CmpWidth   = ProdWidth + 1;

  localparam logic [NumWidth-1:0]   HalfPeriodNum   = 28'd180000000;
  localparam logic [SpeedWidth-1:0] StopSpeedMax    = 16'd3;
  localparam logic [15:0]           HalfPeriodReset = 16'd1000;
  localparam logic [PpmWidth-1:0]   PpmReset        = 16'd100;

  localparam logic ActTick  = 1'b0;
  localparam logic ActSpeed = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [SpeedWidth-1:0] speed;
  } in_word_t;

  typedef struct packed {
    logic pulse_level;
    logic active;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SAT
  } stpg_state_e;

endpackage

@@ hw/rtl/speed_to_pulse_generator.sv @@
// ----------------------------------------------------------------------------
// speed_to_pulse_generator
// Ground-speed pulse output: ticks advance a half-period counter that toggles the
// level; stop speeds halt it, others set the half period by serial division.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o   in_word_i  (action, speed)
//  out       output     out_valid_o / out_ready_i out_word_o (pulse_level, active)
//  cfg       input      cfg_we_i                  cfg_wdata_i (ppm)
//
//  A tick word or a stopping speed gives its result in the cycle after accept.
//  A running speed word passes a multiply state, 28 restoring divide steps
//  of one quotient bit each, and a saturation state.
//  One word is in work at a time; the output register frees the input side.
//  Reset: stopped, level low, half period 1000, 100 pulses per meter.
// ----------------------------------------------------------------------------
module speed_to_pulse_generator
  import stpg_pkg::*;
#(
  parameter int unsigned PERIOD_WIDTH = 28
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [PpmWidth-1:0] cfg_wdata_i
);

  localparam logic [PERIOD_WIDTH-1:0] PeriodMax = {PERIOD_WIDTH{1'b1}};

  stpg_state_e state_q, state_d;

  logic [PpmWidth-1:0]     ppm_q;
  logic [PERIOD_WIDTH-1:0] hp_q;
  logic [PERIOD_WIDTH-1:0] tick_q;
  logic                    run_q;
  logic                    level_q;
  logic [SpeedWidth-1:0]   speed_q;
  logic [ProdWidth-1:0]    prod_q;
  logic [ProdWidth-1:0]    rem_q;
  logic [NumWidth-1:0]     quo_q;
  logic [StepCntW-1:0]     step_q;
  logic                    out_valid_q;
  out_word_t               out_q;

  logic                    in_fire;
  logic                    out_free;
  logic                    is_stop;
  logic                    last_step;
  logic [PERIOD_WIDTH-1:0] tick_inc;
  logic                    wrap;
  logic [CmpWidth-1:0]     rem_sh;
  logic [CmpWidth-1:0]     div_x;
  logic                    ge;
  logic [CmpWidth-1:0]     diff;
  logic [CmpWidth-1:0]     q_x;
  logic [CmpWidth-1:0]     pmax_x;
  logic [PERIOD_WIDTH-1:0] sat_hp;

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_fire   = in_valid_i && in_ready_o;
  assign is_stop   = in_word_i.speed <= StopSpeedMax;
  assign last_step = step_q == StepCntW'(NumWidth - 1);

  assign tick_inc = tick_q + PERIOD_WIDTH'(1);
  assign wrap     = tick_inc >= hp_q;

  assign rem_sh = {rem_q, quo_q[NumWidth-1]};
  assign div_x  = {1'b0, prod_q};
  assign ge     = rem_sh >= div_x;
  assign diff   = rem_sh - div_x;

  assign q_x    = CmpWidth'(quo_q);
  assign pmax_x = CmpWidth'(PeriodMax);

  always_comb begin
    if (prod_q == '0) begin
      sat_hp = PeriodMax;
    end else if (q_x > pmax_x) begin
      sat_hp = PeriodMax;
    end else if (quo_q == '0) begin
      sat_hp = PERIOD_WIDTH'(1);
    end else begin
      sat_hp = q_x[PERIOD_WIDTH-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_word_i.action == ActSpeed && !is_stop) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (last_step) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q) inside
      ST_IDLE: in_ready_o = out_free;
      ST_MUL, ST_DIV, ST_SAT: in_ready_o = 1'b0;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ppm_q       <= PpmReset;
      hp_q        <= PERIOD_WIDTH'(HalfPeriodReset);
      tick_q      <= '0;
      run_q       <= 1'b0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        ppm_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        if (in_word_i.action == ActTick) begin
          tick_q <= wrap ? '0 : tick_inc;
          out_valid_q       <= 1'b1;
          out_q.active      <= run_q;
          out_q.pulse_level <= (wrap && run_q) ? !level_q : level_q;
          if (wrap && run_q) begin
            level_q <= !level_q;
          end
        end else if (is_stop) begin
          run_q             <= 1'b0;
          level_q           <= 1'b0;
          out_valid_q       <= 1'b1;
          out_q.active      <= 1'b0;
          out_q.pulse_level <= 1'b0;
        end
      end
      if (state_q == ST_SAT) begin
        hp_q              <= sat_hp;
        run_q             <= 1'b1;
        out_valid_q       <= 1'b1;
        out_q.active      <= 1'b1;
        out_q.pulse_level <= level_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      speed_q <= in_word_i.speed;
    end
    if (state_q == ST_MUL) begin
      prod_q <= ProdWidth'(speed_q) * ProdWidth'(ppm_q);
      rem_q  <= '0;
      quo_q  <= HalfPeriodNum;
      step_q <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_q  <= ge ? diff[ProdWidth-1:0] : rem_sh[ProdWidth-1:0];
      quo_q  <= {quo_q[NumWidth-2:0], ge};
      step_q <= step_q + StepCntW'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !out_valid_q)
    else $error("result pending while a speed word is in work");

  a_hp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hp_q != '0)
    else $error("half period is zero");

  a_tick_below_hp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_word_i.action == ActTick |=> tick_q < hp_q)
    else $error("tick counter not below half period after a tick");

  a_stopped_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> !level_q)
    else $error("level high while stopped");
`endif

endmodule
